>>> rtl/lob_pkg.sv
// Shared types and constants for the order book best bid/offer core.
// Used by lob_ctrl, lob_dp and limit_order_book_bbo_core; no dependencies.
package lob_pkg;

  localparam int ID_W        = 12;
  localparam int PX_W        = 10;
  localparam int QTY_W       = 32;
  localparam int TOT_W       = 44;
  localparam int ORDER_SLOTS = 4096;
  localparam int PRICE_TICKS = 1024;
  // occupancy maps are held as rows of ROW_W level bits
  localparam int ROW_W       = 32;
  localparam int BIT_AW      = $clog2(ROW_W);
  localparam int ROWS        = PRICE_TICKS / ROW_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int ORD_W       = 1 + 1 + PX_W + QTY_W;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 112;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TRADE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_DUP     = 2'd2,
    STS_EXCEED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_BID   = 2'd1,
    UPD_OFFER = 2'd2
  } upd_t;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_PURGE   = 2'd1,
    OP_PARTIAL = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORD,
    S_EVAL,
    S_LVL,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_TOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic lvl;
    logic scan_chk;
    logic scan_tot;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic noop;
    logic need_scan;
    logic row_hit;
    logic last_row;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/lob_ctrl.sv
// Sequencer for the order book core: clearing pass, event phases, level scan.
// Depends on lob_pkg.
module lob_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lob_pkg::sts_t sts,
  output lob_pkg::cmd_t cmd
);
  import lob_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ORD;
        end
      end
      S_ORD: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.noop ? S_DONE : S_LVL;
      end
      S_LVL: begin
        cmd.lvl   = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN_RD : S_DONE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (sts.row_hit)       state_nxt = S_SCAN_TOT;
        else if (sts.last_row) state_nxt = S_DONE;
        else                   state_nxt = S_SCAN_RD;
      end
      S_SCAN_TOT: begin
        cmd.scan_tot = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // one phase command at most in any cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.eval, cmd.lvl, cmd.scan_chk, cmd.scan_tot, cmd.finish}))
    else $error("more than one phase command");

  // an item is taken only after the clearing pass
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_tready)
    else $error("input ready during clearing pass");

  // a scan follows only a level phase that asked for it
  a_scan_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD) |-> ($past(state_r) == S_LVL || $past(state_r) == S_SCAN_CHK))
    else $error("scan entered from wrong phase");

endmodule

>>> rtl/lob_dp.sv
// Datapath: order store, level totals, occupancy maps, best registers, output.
// Depends on lob_pkg; driven by lob_ctrl commands.
module lob_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lob_pkg::cmd_t                   cmd,
  output lob_pkg::sts_t                   sts,
  input  logic [lob_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lob_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [3:0]                      out_tuser
);
  import lob_pkg::*;

  // memories
  logic [ORD_W-1:0] ord_mem  [ORDER_SLOTS];
  logic [TOT_W-1:0] lvl_mem  [PRICE_TICKS];
  logic [ROW_W-1:0] bmap_mem [ROWS];
  logic [ROW_W-1:0] omap_mem [ROWS];

  logic [ORD_W-1:0] ord_q;
  logic [TOT_W-1:0] tot_q;
  logic [ROW_W-1:0] bmap_q, omap_q;

  // latched event
  kind_t            kind_r;
  logic [ID_W-1:0]  id_r;
  logic             side_in_r;
  logic [PX_W-1:0]  px_in_r;
  logic [QTY_W-1:0] qty_in_r;

  // resolved event
  op_t              op_r;
  status_t          stat_r;
  upd_t             upd_r;
  logic             s_r;
  logic [PX_W-1:0]  p_r;
  logic [QTY_W-1:0] q_r;

  // best registers
  logic             bb_v_r, bo_v_r;
  logic [PX_W-1:0]  bb_p_r, bo_p_r;
  logic [TOT_W-1:0] bb_q_r, bo_q_r;

  // scan and clear
  logic [ROW_AW-1:0] row_r;
  logic [PX_W-1:0]   at_r;
  logic [ID_W-1:0]   clr_r;

  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [3:0]            out_user_r;

  // order word fields
  logic             o_live, o_side;
  logic [PX_W-1:0]  o_px;
  logic [QTY_W-1:0] o_qty;
  assign {o_live, o_side, o_px, o_qty} = ord_q;

  // evaluation of the order read
  status_t          ev_stat;
  op_t              ev_op;
  logic             ev_noop;
  logic             ev_s;
  logic [PX_W-1:0]  ev_p;
  logic [QTY_W-1:0] ev_q;
  logic [ORD_W-1:0] ev_word;

  always_comb begin
    ev_stat = STS_OK;
    ev_op   = OP_ADD;
    ev_noop = 1'b0;
    ev_s    = o_side;
    ev_p    = o_px;
    ev_q    = qty_in_r;
    ev_word = {1'b1, side_in_r, px_in_r, qty_in_r};
    unique case (kind_r)
      KIND_ADD: begin
        ev_s = side_in_r;
        ev_p = px_in_r;
        if (o_live) begin
          ev_stat = STS_DUP;
          ev_noop = 1'b1;
        end
      end
      KIND_CANCEL: begin
        ev_op   = OP_PURGE;
        ev_q    = o_qty;
        ev_word = {1'b0, o_side, o_px, o_qty};
        if (!o_live) begin
          ev_stat = STS_UNKNOWN;
          ev_noop = 1'b1;
        end
      end
      KIND_TRADE: begin
        if (!o_live) begin
          ev_stat = STS_UNKNOWN;
          ev_noop = 1'b1;
        end else if (qty_in_r > o_qty) begin
          ev_stat = STS_EXCEED;
          ev_noop = 1'b1;
        end else if (qty_in_r == o_qty) begin
          ev_op   = OP_PURGE;
          ev_word = {1'b0, o_side, o_px, o_qty};
        end else begin
          ev_op   = OP_PARTIAL;
          ev_word = {1'b1, o_side, o_px, o_qty - qty_in_r};
        end
      end
      default: ev_noop = 1'b1;
    endcase
  end

  // level phase arithmetic
  logic [BIT_AW-1:0] p_bit;
  logic              pres_b, pres_o, empty_lvl;
  logic [TOT_W-1:0]  q_ext, new_tot;
  logic              cur_v;
  logic [PX_W-1:0]   cur_p;
  logic [TOT_W-1:0]  cur_q;
  logic              better, red_hit, red_all;

  assign p_bit     = p_r[BIT_AW-1:0];
  assign pres_b    = bmap_q[p_bit];
  assign pres_o    = omap_q[p_bit];
  assign empty_lvl = !pres_b && !pres_o;
  assign q_ext     = {{(TOT_W-QTY_W){1'b0}}, q_r};
  assign cur_v     = s_r ? bo_v_r : bb_v_r;
  assign cur_p     = s_r ? bo_p_r : bb_p_r;
  assign cur_q     = s_r ? bo_q_r : bb_q_r;
  assign better    = s_r ? (p_r < cur_p) : (p_r > cur_p);
  assign red_hit   = cur_v && (cur_p == p_r);
  assign red_all   = red_hit && (cur_q == q_ext);

  always_comb begin
    if (op_r == OP_ADD) begin
      new_tot = empty_lvl ? q_ext : tot_q + q_ext;
    end else begin
      new_tot = tot_q - q_ext;
    end
  end

  // scan row search: highest bid bit or lowest offer bit
  logic [ROW_W-1:0]  scan_row;
  logic [BIT_AW-1:0] hi_bit, lo_bit, hit_bit;
  logic [PX_W-1:0]   at_nxt;

  assign scan_row = s_r ? omap_q : bmap_q;

  always_comb begin
    hi_bit = '0;
    lo_bit = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (scan_row[i]) hi_bit = BIT_AW'(i);
    end
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (scan_row[i]) lo_bit = BIT_AW'(i);
    end
  end

  assign hit_bit = s_r ? lo_bit : hi_bit;
  assign at_nxt  = {row_r, hit_bit};

  // status to the sequencer
  always_comb begin
    sts            = '0;
    sts.clear_done = (clr_r == ID_W'(ORDER_SLOTS - 1));
    sts.noop       = ev_noop;
    sts.need_scan  = (op_r != OP_ADD) && red_all;
    sts.row_hit    = |scan_row;
    sts.last_row   = s_r ? (row_r == ROW_AW'(ROWS - 1)) : (row_r == '0);
    sts.out_free   = !out_valid_r || out_tready;
  end

  // memory addresses
  logic [PX_W-1:0]   lvl_ra;
  logic [ROW_AW-1:0] map_ra;
  assign lvl_ra = cmd.scan_chk ? at_nxt : ev_p;
  assign map_ra = cmd.eval ? ev_p[PX_W-1:BIT_AW] : row_r;

  // order store
  always_ff @(posedge clk) begin
    ord_q <= ord_mem[id_r];
    if (cmd.clear) begin
      ord_mem[clr_r] <= '0;
    end else if (cmd.eval && !ev_noop) begin
      ord_mem[id_r] <= ev_word;
    end
  end

  // level totals
  always_ff @(posedge clk) begin
    tot_q <= lvl_mem[lvl_ra];
    if (cmd.lvl) lvl_mem[p_r] <= new_tot;
  end

  // occupancy maps
  logic [ROW_W-1:0] bit_mask;
  logic             map_set, map_clr;
  assign bit_mask = ROW_W'(1) << p_bit;
  assign map_set  = (op_r == OP_ADD) && empty_lvl;
  assign map_clr  = (op_r == OP_PURGE) && (new_tot == '0);

  always_ff @(posedge clk) begin
    bmap_q <= bmap_mem[map_ra];
    omap_q <= omap_mem[map_ra];
    if (cmd.clear) begin
      bmap_mem[clr_r[ROW_AW-1:0]] <= '0;
      omap_mem[clr_r[ROW_AW-1:0]] <= '0;
    end else if (cmd.lvl && (map_set || map_clr)) begin
      if (!s_r) begin
        bmap_mem[p_r[PX_W-1:BIT_AW]] <= map_set ? (bmap_q | bit_mask) : (bmap_q & ~bit_mask);
      end else begin
        omap_mem[p_r[PX_W-1:BIT_AW]] <= map_set ? (omap_q | bit_mask) : (omap_q & ~bit_mask);
      end
    end
  end

  // event latch and resolution
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= kind_t'(in_tuser);
      id_r      <= in_tdata[ID_W-1:0];
      side_in_r <= in_tdata[ID_W];
      px_in_r   <= in_tdata[ID_W+PX_W:ID_W+1];
      qty_in_r  <= in_tdata[ID_W+PX_W+QTY_W:ID_W+PX_W+1];
    end
    if (cmd.eval) begin
      stat_r <= ev_stat;
      op_r   <= ev_op;
      s_r    <= ev_s;
      p_r    <= ev_p;
      q_r    <= ev_q;
    end
    if (cmd.lvl) row_r <= s_r ? '0 : ROW_AW'(ROWS - 1);
    if (cmd.scan_chk && !sts.row_hit) row_r <= s_r ? row_r + 1'b1 : row_r - 1'b1;
    if (cmd.scan_chk) at_r <= at_nxt;
  end

  // best registers and update code
  logic             nb_v;
  logic [PX_W-1:0]  nb_p;
  logic [TOT_W-1:0] nb_q;
  logic             nb_we;
  upd_t             side_code;
  assign side_code = s_r ? UPD_OFFER : UPD_BID;

  always_comb begin
    nb_v  = cur_v;
    nb_p  = cur_p;
    nb_q  = cur_q;
    nb_we = 1'b0;
    if (cmd.lvl) begin
      if (op_r == OP_ADD) begin
        if (!cur_v || better) begin
          {nb_v, nb_p, nb_q} = {1'b1, p_r, q_ext};
          nb_we = 1'b1;
        end else if (p_r == cur_p) begin
          nb_q  = cur_q + q_ext;
          nb_we = 1'b1;
        end
      end else if (red_hit && !red_all) begin
        nb_q  = cur_q - q_ext;
        nb_we = 1'b1;
      end
    end else if (cmd.scan_chk && !sts.row_hit && sts.last_row) begin
      {nb_v, nb_p, nb_q} = '0;
      nb_we = 1'b1;
    end else if (cmd.scan_tot) begin
      {nb_v, nb_p, nb_q} = {1'b1, at_r, tot_q};
      nb_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_v_r <= 1'b0;
      bb_p_r <= '0;
      bb_q_r <= '0;
      bo_v_r <= 1'b0;
      bo_p_r <= '0;
      bo_q_r <= '0;
      clr_r  <= '0;
      upd_r  <= UPD_NONE;
    end else begin
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (nb_we && !s_r) {bb_v_r, bb_p_r, bb_q_r} <= {nb_v, nb_p, nb_q};
      if (nb_we && s_r)  {bo_v_r, bo_p_r, bo_q_r} <= {nb_v, nb_p, nb_q};
      if (cmd.eval) upd_r <= UPD_NONE;
      if (cmd.lvl && (nb_we || red_all)) upd_r <= side_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_user_r <= {stat_r, upd_r};
      out_data_r <= {2'b00, bo_q_r, bo_p_r, bo_v_r, bb_q_r, bb_p_r, bb_v_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // an invalid best always reads as price and quantity zero
  a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !bb_v_r |-> (bb_p_r == '0 && bb_q_r == '0))
    else $error("invalid best bid not zero");

  a_offer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !bo_v_r |-> (bo_p_r == '0 && bo_q_r == '0))
    else $error("invalid best offer not zero");

  // a finished event is always presented
  a_finish_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished item not presented");

endmodule

>>> rtl/limit_order_book_bbo_core.sv
// Top level of the order book best bid/offer core.
// Depends on lob_pkg, lob_ctrl and lob_dp.
//
// Takes add, cancel and trade events and returns, for each, an update code, a status
// and the current best bid and best offer. After reset the block runs a clearing pass
// over the order store (and the level maps) before in_tready first rises. An event
// that touches the book passes, after acceptance, through order store read,
// evaluation, level read and update, and output load. A flagged event or the unused
// kind skips the level phase. When the best level empties, the next best is found by
// scanning the side's level map one 32-level row at a time, a read and then a check
// per row; the map row scan sets the worst case. One event is in work at a time and
// in_tready rises the cycle after the result is loaded, so a new event is taken only
// once the last is through. The output register holds a result while the next event
// is accepted; a result still waiting holds back only the loading of the next one.
module limit_order_book_bbo_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // order_slot[11:0], side[12], price[22:13], quantity[54:23], zero fill
  input  logic [lob_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bid_valid[0], best_bid_price[10:1], best_bid_qty[54:11], offer_valid[55],
  // best_offer_price[65:56], best_offer_qty[109:66], zero fill
  output logic [lob_pkg::OUT_DATA_W-1:0]  out_tdata,
  // update[1:0], status[3:2]
  output logic [3:0]                      out_tuser
);
  import lob_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lob_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> dv/tb_limit_order_book_bbo_core.sv
// Self-checking testbench for limit_order_book_bbo_core: directed table, then random events.
// Depends on lob_pkg (event kinds, status and update codes, widths) and the core itself.
module tb_limit_order_book_bbo_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lob_pkg::*;

  typedef struct packed {
    upd_t              upd;
    status_t           sts;
    logic              bid_v;
    logic [PX_W-1:0]   bid_px;
    logic [TOT_W-1:0]  bid_qty;
    logic              ofr_v;
    logic [PX_W-1:0]   ofr_px;
    logic [TOT_W-1:0]  ofr_qty;
  } quote_t;

  typedef struct {
    kind_t             k;
    logic [ID_W-1:0]   id;
    logic              sd;
    logic [PX_W-1:0]   px;
    logic [QTY_W-1:0]  q;
    bit                typed;
    quote_t            e;
  } event_row_t;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1500;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [3:0]             out_tuser;

  limit_order_book_bbo_core dut (.*);

  // book mirror used to predict each quote
  bit                 bk_live [ORDER_SLOTS];
  bit                 bk_side [ORDER_SLOTS];
  logic [PX_W-1:0]    bk_px   [ORDER_SLOTS];
  logic [QTY_W-1:0]   bk_qty  [ORDER_SLOTS];
  logic [TOT_W-1:0]   lvl_tot [PRICE_TICKS];
  bit                 bid_map [PRICE_TICKS];
  bit                 ofr_map [PRICE_TICKS];
  bit                 bb_v, bo_v;
  logic [PX_W-1:0]    bb_px, bo_px;
  logic [TOT_W-1:0]   bb_qty, bo_qty;
  int                 live_ids[$];

  quote_t quotes_due[$];
  int     n_errors;
  int     n_checked;
  int     idle_cycles;
  int     n_sent;
  bit     stall_free;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic void drop_live(input int id);
    foreach (live_ids[i]) if (live_ids[i] == id) begin
      live_ids.delete(i);
      break;
    end
  endfunction

  // take q off the best of one side; rescan the level map when it is used up
  function automatic upd_t shrink_best(input bit sd, input logic [PX_W-1:0] px,
                                       input logic [TOT_W-1:0] q);
    bit found;
    int at;
    found = 1'b0;
    at = 0;
    if (!sd) begin
      if (!bb_v || bb_px != px) return UPD_NONE;
      if (bb_qty == q) begin
        for (int i = PRICE_TICKS - 1; i >= 0; i--) if (bid_map[i]) begin
          at = i; found = 1'b1; break;
        end
        bb_v = found;
        bb_px = found ? PX_W'(at) : '0;
        bb_qty = found ? lvl_tot[at] : '0;
      end else bb_qty = bb_qty - q;
      return UPD_BID;
    end
    if (!bo_v || bo_px != px) return UPD_NONE;
    if (bo_qty == q) begin
      for (int i = 0; i < PRICE_TICKS; i++) if (ofr_map[i]) begin
        at = i; found = 1'b1; break;
      end
      bo_v = found;
      bo_px = found ? PX_W'(at) : '0;
      bo_qty = found ? lvl_tot[at] : '0;
    end else bo_qty = bo_qty - q;
    return UPD_OFFER;
  endfunction

  function automatic upd_t remove_order(input int id);
    logic [PX_W-1:0] px;
    px = bk_px[id];
    lvl_tot[px] = lvl_tot[px] - bk_qty[id];
    if (lvl_tot[px] == 0) begin
      if (bk_side[id]) ofr_map[px] = 1'b0;
      else bid_map[px] = 1'b0;
    end
    bk_live[id] = 1'b0;
    drop_live(id);
    return shrink_best(bk_side[id], px, TOT_W'(bk_qty[id]));
  endfunction

  function automatic upd_t rest_order(input int id, input bit sd, input logic [PX_W-1:0] px,
                                      input logic [QTY_W-1:0] q);
    bit better;
    bk_live[id] = 1'b1;
    bk_side[id] = sd;
    bk_px[id] = px;
    bk_qty[id] = q;
    live_ids.push_back(id);
    if (!bid_map[px] && !ofr_map[px]) begin
      lvl_tot[px] = TOT_W'(q);
      if (sd) ofr_map[px] = 1'b1;
      else bid_map[px] = 1'b1;
    end else lvl_tot[px] = lvl_tot[px] + q;
    if (!sd) begin
      better = px > bb_px;
      if (!bb_v || better) begin
        bb_v = 1'b1; bb_px = px; bb_qty = TOT_W'(q);
        return UPD_BID;
      end
      if (px == bb_px) begin
        bb_qty = bb_qty + q;
        return UPD_BID;
      end
      return UPD_NONE;
    end
    better = px < bo_px;
    if (!bo_v || better) begin
      bo_v = 1'b1; bo_px = px; bo_qty = TOT_W'(q);
      return UPD_OFFER;
    end
    if (px == bo_px) begin
      bo_qty = bo_qty + q;
      return UPD_OFFER;
    end
    return UPD_NONE;
  endfunction

  // apply one event to the mirror and return the quote it should produce
  function automatic quote_t book_event(input kind_t k, input int id, input bit sd,
                                        input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
    quote_t r;
    r.upd = UPD_NONE;
    r.sts = STS_OK;
    case (k)
      KIND_ADD: begin
        if (bk_live[id]) r.sts = STS_DUP;
        else r.upd = rest_order(id, sd, px, q);
      end
      KIND_CANCEL: begin
        if (!bk_live[id]) r.sts = STS_UNKNOWN;
        else r.upd = remove_order(id);
      end
      KIND_TRADE: begin
        if (!bk_live[id]) r.sts = STS_UNKNOWN;
        else if (q > bk_qty[id]) r.sts = STS_EXCEED;
        else if (q == bk_qty[id]) r.upd = remove_order(id);
        else begin
          bk_qty[id] = bk_qty[id] - q;
          lvl_tot[bk_px[id]] = lvl_tot[bk_px[id]] - q;
          r.upd = shrink_best(bk_side[id], bk_px[id], TOT_W'(q));
        end
      end
      default: ;
    endcase
    r.bid_v = bb_v; r.bid_px = bb_px; r.bid_qty = bb_qty;
    r.ofr_v = bo_v; r.ofr_px = bo_px; r.ofr_qty = bo_qty;
    return r;
  endfunction

  // present one item and hold it until accepted, then maybe idle
  task automatic send(input event_row_t ev);
    int gap;
    int r;
    quote_t want;
    want = book_event(ev.k, ev.id, ev.sd, ev.px, ev.q);
    quotes_due.push_back(ev.typed ? ev.e : want);
    in_tvalid <= 1'b1;
    in_tuser  <= ev.k;
    in_tdata  <= {1'b0, ev.q, ev.px, ev.sd, ev.id};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    r = $urandom_range(0, 99);
    gap = stall_free ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (quotes_due.size() != 0) @(posedge clk);
  endtask

  function automatic event_row_t mk(input kind_t k, input int id, input bit sd, input int px,
                                    input logic [QTY_W-1:0] q);
    event_row_t ev;
    ev.k = k; ev.id = ID_W'(id); ev.sd = sd; ev.px = PX_W'(px); ev.q = q;
    ev.typed = 1'b0;
    ev.e = '0;
    return ev;
  endfunction

  function automatic event_row_t mk_typed(input event_row_t ev, input quote_t e);
    ev.typed = 1'b1;
    ev.e = e;
    return ev;
  endfunction

  function automatic event_row_t random_event();
    event_row_t ev;
    int r, id;
    logic [QTY_W-1:0] oq;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ORDER_SLOTS - 1)
                                     : $urandom_range(0, 63);
    ev = mk(KIND_ADD, id, $urandom_range(0, 1),
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, PRICE_TICKS - 1)
                                        : $urandom_range(496, 527),
            ($urandom_range(0, 9) == 0) ? QTY_W'($urandom) : QTY_W'($urandom_range(0, 200)));
    if (r < 45 || live_ids.size() == 0) begin
      // fresh order; sometimes a repeated slot
      if (r < 40 && live_ids.size() != 0 && $urandom_range(0, 9) == 0)
        ev.id = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      return ev;
    end
    if (r >= 92) begin
      // noise: unused kind or events on a random slot
      ev.k = kind_t'($urandom_range(1, 3));
      return ev;
    end
    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    ev.id = ID_W'(id);
    oq = bk_qty[id];
    if (r < 65) begin
      ev.k = KIND_CANCEL;
      return ev;
    end
    ev.k = KIND_TRADE;
    r = $urandom_range(0, 9);
    if (r < 4) ev.q = oq;
    else if (r < 9 && oq != 0) ev.q = QTY_W'($urandom_range(0, 1000000)) % oq;
    else if (oq != '1) ev.q = oq + 1;
    return ev;
  endfunction

  // result checker, sink stalls and watchdog
  always @(posedge clk) begin
    quote_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_tready <= stall_free ? 1'b1 : ($urandom_range(0, 99) < 70) ? 1'b1 :
                    ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG);
        $display("tb_limit_order_book_bbo_core: errors");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {upd_t'(out_tuser[1:0]), status_t'(out_tuser[3:2]), out_tdata[0],
               out_tdata[10:1], out_tdata[54:11], out_tdata[55], out_tdata[65:56],
               out_tdata[109:66]};
        if (quotes_due.size() == 0) begin
          report("unexpected quote", got[63:0], '0);
        end else begin
          want = quotes_due.pop_front();
          n_checked++;
          if (got.upd !== want.upd) report("update", got.upd, want.upd);
          if (got.sts !== want.sts) report("status", got.sts, want.sts);
          if (got.bid_v !== want.bid_v) report("bid_valid", got.bid_v, want.bid_v);
          if (got.bid_px !== want.bid_px) report("bid_price", got.bid_px, want.bid_px);
          if (got.bid_qty !== want.bid_qty) report("bid_qty", got.bid_qty, want.bid_qty);
          if (got.ofr_v !== want.ofr_v) report("offer_valid", got.ofr_v, want.ofr_v);
          if (got.ofr_px !== want.ofr_px) report("offer_price", got.ofr_px, want.ofr_px);
          if (got.ofr_qty !== want.ofr_qty) report("offer_qty", got.ofr_qty, want.ofr_qty);
        end
      end
    end
  end

  // stimulus
  initial begin
    event_row_t rows[$];
    quote_t z;
    int tries;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_NONE;
    out_tready = 1'b0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    stall_free = 1'b0;
    bb_v = 0; bb_px = '0; bb_qty = '0;
    bo_v = 0; bo_px = '0; bo_qty = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: empty book, extremes, codes, shared level and rescans
    z = '0;
    rows.push_back(mk_typed(mk(KIND_CANCEL, 5, 0, 0, 0),
                            '{UPD_NONE, STS_UNKNOWN, 0, 0, 0, 0, 0, 0}));
    rows.push_back(mk_typed(mk(KIND_TRADE, 0, 1, 1023, '1),
                            '{UPD_NONE, STS_UNKNOWN, 0, 0, 0, 0, 0, 0}));
    rows.push_back(mk_typed(mk(KIND_NONE, 4095, 1, 1023, '1), z));
    rows.push_back(mk_typed(mk(KIND_ADD, 0, 0, 1023, '1),
                            '{UPD_BID, STS_OK, 1, 10'd1023, 44'hffffffff, 0, 0, 0}));
    rows.push_back(mk_typed(mk(KIND_ADD, 0, 1, 3, 9),
                            '{UPD_NONE, STS_DUP, 1, 10'd1023, 44'hffffffff, 0, 0, 0}));
    rows.push_back(mk_typed(mk(KIND_ADD, 4095, 1, 0, 1),
                            '{UPD_OFFER, STS_OK, 1, 10'd1023, 44'hffffffff, 1, 0, 1}));
    rows.push_back(mk_typed(mk(KIND_TRADE, 4095, 0, 0, 2),
                            '{UPD_NONE, STS_EXCEED, 1, 10'd1023, 44'hffffffff, 1, 0, 1}));
    rows.push_back(mk(KIND_ADD, 1, 0, 1023, '1));
    rows.push_back(mk(KIND_ADD, 2, 0, 500, 7));
    rows.push_back(mk(KIND_TRADE, 0, 0, 0, 5));
    rows.push_back(mk(KIND_CANCEL, 1, 0, 0, 0));
    rows.push_back(mk(KIND_CANCEL, 0, 0, 0, 0));
    rows.push_back(mk(KIND_ADD, 3, 1, 500, 3));
    rows.push_back(mk(KIND_TRADE, 4095, 0, 0, 1));
    rows.push_back(mk(KIND_CANCEL, 2, 0, 0, 0));
    rows.push_back(mk(KIND_ADD, 4, 0, 0, 0));
    rows.push_back(mk(KIND_TRADE, 4, 0, 0, 0));
    rows.push_back(mk(KIND_ADD, 5, 1, 1023, 12));
    rows.push_back(mk(KIND_ADD, 6, 1, 700, 4));
    rows.push_back(mk(KIND_TRADE, 6, 0, 0, 4));
    rows.push_back(mk(KIND_CANCEL, 3, 0, 0, 0));
    rows.push_back(mk(KIND_CANCEL, 5, 0, 0, 0));
    foreach (rows[i]) send(rows[i]);

    // let the book settle before the random part
    drain();

    // random events, with stall-free stretches and a mid-run drain
    for (int i = 0; i < N_RANDOM; i++) begin
      stall_free = (i / 100) % 5 == 2;
      if (i == N_RANDOM / 2) drain();
      send(random_event());
    end
    drain();

    // trailing quiet time for anything unexpected
    tries = 0;
    while (tries < 100) begin
      @(posedge clk);
      tries++;
    end
    $display("sent %0d events (directed and random), checked %0d quotes", n_sent, n_checked);
    $display("covered adds, cancels, trades, unknown/duplicate/oversize cases, level rescans");
    if (n_errors == 0 && quotes_due.size() == 0) begin
      $display("tb_limit_order_book_bbo_core: clean");
    end else begin
      $display("tb_limit_order_book_bbo_core: errors");
    end
    $finish;
  end

endmodule
